FILE: design/rd_pkg.sv
package rd_pkg;

    localparam int DEPTH    = 1024;
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [2:0]          t_cell_op;

    localparam t_func FUNC_PUSH_FRONT = 3'd0;
    localparam t_func FUNC_POP_FRONT  = 3'd1;
    localparam t_func FUNC_PUSH_BACK  = 3'd2;
    localparam t_func FUNC_POP_BACK   = 3'd3;
    localparam t_func FUNC_TOGGLE     = 3'd4;
    localparam t_func FUNC_END_SWAP   = 3'd2;

    localparam t_status STATUS_DONE   = 2'd0;
    localparam t_status STATUS_POPPED = 2'd1;
    localparam t_status STATUS_EMPTY  = 2'd2;
    localparam t_status STATUS_FULL   = 2'd3;

    localparam t_cell_op OP_HOLD      = 3'd0;
    localparam t_cell_op OP_SHIFT_IN  = 3'd1;
    localparam t_cell_op OP_SHIFT_OUT = 3'd2;
    localparam t_cell_op OP_APPEND    = 3'd3;
    localparam t_cell_op OP_TRIM      = 3'd4;

    typedef struct packed {
        t_func                    func;
        logic signed [DATA_W-1:0] push_value;
    } t_in;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] pop_value;
    } t_out;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
    } t_link;

endpackage

FILE: design/reversible_deque.sv
// Bounded deque of signed 32-bit words with a reverse flag. One command is
// taken per cycle and its result appears in the output register on the next
// cycle; a new command is taken while that result waits, as long as the
// output register is free or being drained in the same cycle. The contents
// live in two mirrored chains of DEPTH cells: one keeps the front entry in its
// first cell, the other keeps the back entry in its first cell, so every push
// or pop that succeeds is a shift, append or trim across the cells. There is no
// clearing pass: the chains are empty as soon as reset is released.
module reversible_deque (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  rd_pkg::t_in  i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output rd_pkg::t_out o_out_data
);

    logic             w_accept;
    rd_pkg::t_func    w_eff;
    rd_pkg::t_cell_op w_front_op;
    rd_pkg::t_cell_op w_back_op;
    rd_pkg::t_link    w_front_head;
    rd_pkg::t_link    w_back_head;
    logic             w_front_full;
    logic             w_back_full;
    logic             w_full;
    logic             w_empty;

    logic             r_reversed;
    logic             n_reversed;
    logic             r_out_valid;
    rd_pkg::t_out     r_out;
    rd_pkg::t_out     n_out;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = w_front_full;
    assign w_empty    = !w_front_head.valid;
    assign w_eff      = r_reversed ? (i_in_data.func ^ rd_pkg::FUNC_END_SWAP)
                                   : i_in_data.func;

    always_comb begin
        w_front_op      = rd_pkg::OP_HOLD;
        w_back_op       = rd_pkg::OP_HOLD;
        n_reversed      = r_reversed;
        n_out.status    = rd_pkg::STATUS_DONE;
        n_out.pop_value = '0;
        if (w_accept) begin
            if (i_in_data.func == rd_pkg::FUNC_TOGGLE) begin
                n_reversed = !r_reversed;
            end else if (i_in_data.func inside {rd_pkg::FUNC_PUSH_FRONT,
                    rd_pkg::FUNC_POP_FRONT, rd_pkg::FUNC_PUSH_BACK,
                    rd_pkg::FUNC_POP_BACK}) begin
                case (w_eff)
                    rd_pkg::FUNC_PUSH_FRONT: begin
                        if (w_full) begin
                            n_out.status = rd_pkg::STATUS_FULL;
                        end else begin
                            w_front_op = rd_pkg::OP_SHIFT_IN;
                            w_back_op  = rd_pkg::OP_APPEND;
                        end
                    end
                    rd_pkg::FUNC_POP_FRONT: begin
                        if (w_empty) begin
                            n_out.status = rd_pkg::STATUS_EMPTY;
                        end else begin
                            n_out.status    = rd_pkg::STATUS_POPPED;
                            n_out.pop_value = w_front_head.data;
                            w_front_op      = rd_pkg::OP_SHIFT_OUT;
                            w_back_op       = rd_pkg::OP_TRIM;
                        end
                    end
                    rd_pkg::FUNC_PUSH_BACK: begin
                        if (w_full) begin
                            n_out.status = rd_pkg::STATUS_FULL;
                        end else begin
                            w_front_op = rd_pkg::OP_APPEND;
                            w_back_op  = rd_pkg::OP_SHIFT_IN;
                        end
                    end
                    rd_pkg::FUNC_POP_BACK: begin
                        if (w_empty) begin
                            n_out.status = rd_pkg::STATUS_EMPTY;
                        end else begin
                            n_out.status    = rd_pkg::STATUS_POPPED;
                            n_out.pop_value = w_back_head.data;
                            w_front_op      = rd_pkg::OP_TRIM;
                            w_back_op       = rd_pkg::OP_SHIFT_OUT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    rd_chain u_front_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_front_op),
        .i_push_value (i_in_data.push_value),
        .o_head       (w_front_head),
        .o_full       (w_front_full)
    );

    rd_chain u_back_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_back_op),
        .i_push_value (i_in_data.push_value),
        .o_head       (w_back_head),
        .o_full       (w_back_full)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reversed  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_reversed <= n_reversed;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // both chains agree on whether they are full and whether they are empty
    a_chains_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_front_full == w_back_full) && (w_front_head.valid == w_back_head.valid))
        else $error("deque chains disagree on occupancy");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_full && w_empty))
        else $error("deque reports full and empty at once");

    // every transfer in leaves a result behind
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted command produced no result");

endmodule

FILE: design/rd_cell.sv
module rd_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rd_pkg::t_cell_op i_op,
    input  rd_pkg::t_link    i_left,
    input  rd_pkg::t_link    i_right,
    input  logic signed [rd_pkg::DATA_W-1:0] i_push_value,
    output rd_pkg::t_link    o_link
);

    logic                             r_valid;
    logic                             n_valid;
    logic signed [rd_pkg::DATA_W-1:0] r_data;
    logic signed [rd_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        case (i_op)
            rd_pkg::OP_SHIFT_IN: begin
                n_valid = i_left.valid;
                n_data  = i_left.data;
            end
            rd_pkg::OP_SHIFT_OUT: begin
                n_valid = i_right.valid;
                n_data  = i_right.data;
            end
            rd_pkg::OP_APPEND: begin
                // first empty cell takes the word
                if (!r_valid && i_left.valid) begin
                    n_valid = 1'b1;
                    n_data  = i_push_value;
                end
            end
            rd_pkg::OP_TRIM: begin
                // last occupied cell lets go
                if (r_valid && !i_right.valid) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_link.valid = r_valid;
    assign o_link.data  = r_data;

endmodule

FILE: design/rd_chain.sv
module rd_chain (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rd_pkg::t_cell_op i_op,
    input  logic signed [rd_pkg::DATA_W-1:0] i_push_value,
    output rd_pkg::t_link    o_head,
    output logic             o_full
);

    rd_pkg::t_link w_link [rd_pkg::DEPTH];

    genvar g;
    for (g = 0; g < rd_pkg::DEPTH; g++) begin : g_cell
        rd_pkg::t_link w_left;
        rd_pkg::t_link w_right;

        if (g == 0) begin : g_first
            assign w_left.valid = 1'b1;
            assign w_left.data  = i_push_value;
        end else begin : g_inner_left
            assign w_left = w_link[g-1];
        end

        if (g == rd_pkg::DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_right
            assign w_right = w_link[g+1];
        end

        rd_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (i_op),
            .i_left       (w_left),
            .i_right      (w_right),
            .i_push_value (i_push_value),
            .o_link       (w_link[g])
        );
    end

    assign o_head = w_link[0];
    assign o_full = w_link[rd_pkg::DEPTH-1].valid;

endmodule
